// ===== src/rrps_pkg.sv =====
// Shared types and constants for the round-robin poll sequencer.
// Used by rrps_cfg, rrps_core and round_robin_poll_sequencer; depends on nothing.
package rrps_pkg;

  // Register indexes on the configuration port (byte address = 4 * index).
  localparam logic [2:0] REG_SLOT_COUNT = 3'd0;
  localparam logic [2:0] REG_TIMEOUT    = 3'd1;
  localparam logic [2:0] REG_MAX_RUNS0  = 3'd2;

  // Number of run-limit registers on the port.
  localparam int NUM_MAX_RUN_REGS = 4;

  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int LIMIT_W     = 31;
  localparam int SLOT_CNT_W  = 3;
  localparam int ELAPSED_W   = 32;
  localparam int SLOT_IDX_W  = 2;

  typedef enum logic [4:0] {
    PH_START   = 5'b00001,
    PH_SKIP    = 5'b00010,
    PH_WAIT    = 5'b00100,
    PH_TIMEOUT = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic device_ready;
    logic response_ready;
    logic read_ok;
  } in_flags_t;

  typedef struct packed {
    logic                    send_request;
    logic                    read_request;
    logic                    response_event;
    logic                    timeout_event;
    logic [SLOT_IDX_W-1:0]   slot_index;
    logic [ELAPSED_W-1:0]    elapsed_ms;
  } result_t;

endpackage

// ===== src/rrps_cfg.sv =====
// Configuration register file of the round-robin poll sequencer.
// APB-style write and read access; depends on rrps_pkg.
module rrps_cfg #(
  parameter int SLOTS       = 4,
  parameter int COUNT_WIDTH = 31
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rrps_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [rrps_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [rrps_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [rrps_pkg::SLOT_CNT_W-1:0]     slot_count,
  output logic [rrps_pkg::LIMIT_W-1:0]        timeout_limit,
  output logic [COUNT_WIDTH-1:0]              max_runs [SLOTS]
);
  import rrps_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic       wr;
  logic [2:0] idx;
  logic [63:0] wval_ext;
  logic [COUNT_WIDTH-1:0] wval_cnt;

  assign pready   = 1'b1;
  assign wr       = psel && penable && pwrite;
  assign idx      = paddr[4:2];
  assign wval_ext = {33'b0, pwdata[LIMIT_W-1:0]};
  assign wval_cnt = wval_ext[COUNT_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count    <= SLOT_CNT_W'(1);
      timeout_limit <= LIMIT_W'(100);
      for (int k = 0; k < SLOTS; k++) begin
        max_runs[k] <= COUNT_MAX;
      end
    end else if (wr) begin
      if (idx == REG_SLOT_COUNT) begin
        slot_count <= pwdata[SLOT_CNT_W-1:0];
      end
      if (idx == REG_TIMEOUT) begin
        timeout_limit <= pwdata[LIMIT_W-1:0];
      end
      for (int k = 0; k < SLOTS; k++) begin
        if (k < NUM_MAX_RUN_REGS && int'(idx) == int'(REG_MAX_RUNS0) + k) begin
          max_runs[k] <= wval_cnt;
        end
      end
    end
  end

  always_comb begin
    logic [63:0] mr_ext;
    prdata = '0;
    mr_ext = '0;
    if (idx == REG_SLOT_COUNT) begin
      prdata = CFG_DATA_W'(slot_count);
    end else if (idx == REG_TIMEOUT) begin
      prdata = CFG_DATA_W'(timeout_limit);
    end else begin
      for (int k = 0; k < SLOTS; k++) begin
        if (k < NUM_MAX_RUN_REGS && int'(idx) == int'(REG_MAX_RUNS0) + k) begin
          mr_ext = 64'(max_runs[k]);
          prdata = {1'b0, mr_ext[LIMIT_W-1:0]};
        end
      end
    end
  end

endmodule

// ===== src/rrps_core.sv =====
// Poll sequencer state and per-item step logic.
// Holds phase, current slot, send time and run counts; depends on rrps_pkg.
module rrps_core #(
  parameter int SLOTS       = 4,
  parameter int COUNT_WIDTH = 31,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fire,
  input  logic [TIME_WIDTH-1:0]             now_ms,
  input  rrps_pkg::in_flags_t               flags,
  input  logic [rrps_pkg::SLOT_CNT_W-1:0]   slot_count,
  input  logic [rrps_pkg::LIMIT_W-1:0]      timeout_limit,
  input  logic [COUNT_WIDTH-1:0]            max_runs [SLOTS],
  output rrps_pkg::result_t                 res
);
  import rrps_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NW     = ($clog2(SLOTS + 1) > SLOT_CNT_W) ? $clog2(SLOTS + 1) : SLOT_CNT_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  phase_t                phase, phase_next;
  logic [SLOT_W-1:0]     cur, cur_next;
  logic [TIME_WIDTH-1:0] send_time, send_time_next;
  logic [COUNT_WIDTH-1:0] run_counts [SLOTS];

  logic                   cnt_wr;
  logic [COUNT_WIDTH-1:0] cnt_wval;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] mr;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic [63:0]            elapsed_ext;
  logic                   over;
  logic [NW-1:0]          sc_ext;
  logic [NW-1:0]          active;
  logic [NW-1:0]          cur_inc;
  logic                   last;
  logic [15:0]            cur_ext;

  assign cnt         = run_counts[cur];
  assign mr          = max_runs[cur];
  assign elapsed     = now_ms - send_time;
  assign elapsed_ext = 64'(elapsed);
  assign over        = elapsed_ext > 64'(timeout_limit);
  assign sc_ext      = NW'(slot_count);
  assign cur_inc     = NW'(cur) + NW'(1);
  assign last        = cur_inc >= active;
  assign cur_ext     = 16'(cur);

  always_comb begin
    if (sc_ext == '0) begin
      active = NW'(1);
    end else if (sc_ext > NW'(SLOTS)) begin
      active = NW'(SLOTS);
    end else begin
      active = sc_ext;
    end
  end

  always_comb begin
    phase_next     = phase;
    cur_next       = cur;
    send_time_next = send_time;
    cnt_wr         = 1'b0;
    cnt_wval       = cnt;
    res            = '0;
    if (!flags.device_ready) begin
      phase_next = PH_START;
    end else begin
      case (phase)
        PH_START: begin
          phase_next = PH_SKIP;
          cur_next   = '0;
        end
        PH_SKIP: begin
          if (cnt > mr) begin
            phase_next = PH_DONE;
          end else if (cnt == COUNT_MAX) begin
            cnt_wr   = 1'b1;
            cnt_wval = '0;
          end else begin
            cnt_wr           = 1'b1;
            cnt_wval         = cnt + COUNT_WIDTH'(1);
            send_time_next   = now_ms;
            phase_next       = PH_WAIT;
            res.send_request = 1'b1;
            res.slot_index   = cur_ext[SLOT_IDX_W-1:0];
          end
        end
        PH_WAIT: begin
          if (over) begin
            phase_next = PH_TIMEOUT;
          end else if (flags.response_ready) begin
            res.read_request = 1'b1;
            res.slot_index   = cur_ext[SLOT_IDX_W-1:0];
            if (flags.read_ok) begin
              res.response_event = 1'b1;
              res.elapsed_ms     = elapsed_ext[ELAPSED_W-1:0];
            end
            phase_next = PH_DONE;
          end
        end
        PH_TIMEOUT: begin
          res.timeout_event = 1'b1;
          res.slot_index    = cur_ext[SLOT_IDX_W-1:0];
          res.elapsed_ms    = elapsed_ext[ELAPSED_W-1:0];
          if (last) begin
            cur_next   = '0;
            phase_next = PH_START;
          end else begin
            cur_next   = cur_inc[SLOT_W-1:0];
            phase_next = PH_SKIP;
          end
        end
        PH_DONE: begin
          if (last) begin
            cur_next   = '0;
            phase_next = PH_START;
          end else begin
            cur_next   = cur_inc[SLOT_W-1:0];
            phase_next = PH_SKIP;
          end
        end
        default: begin
          phase_next = PH_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_START;
      cur       <= '0;
      send_time <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        run_counts[k] <= '0;
      end
    end else if (fire) begin
      phase     <= phase_next;
      cur       <= cur_next;
      send_time <= send_time_next;
      if (cnt_wr) begin
        run_counts[cur] <= cnt_wval;
      end
    end
  end

  a_send_then_wait: assert property (@(posedge clk) disable iff (rst)
    fire && res.send_request |=> phase == PH_WAIT)
    else $error("send was not followed by the wait phase");

  a_one_strobe: assert property (@(posedge clk) disable iff (rst)
    fire |-> $onehot0({res.send_request, res.read_request, res.timeout_event}))
    else $error("more than one strobe on a result");

  a_event_needs_read: assert property (@(posedge clk) disable iff (rst)
    fire && res.response_event |-> res.read_request && $past(phase_next) != PH_START)
    else $error("response event without a read");

  a_not_ready_start: assert property (@(posedge clk) disable iff (rst)
    fire && !flags.device_ready |=> phase == PH_START && $stable(send_time))
    else $error("losing ready did not return to start");

  a_timeout_reported: assert property (@(posedge clk) disable iff (rst)
    fire && flags.device_ready && phase == PH_TIMEOUT |-> res.timeout_event)
    else $error("timeout phase passed without a timeout event");

endmodule

// ===== src/round_robin_poll_sequencer.sv =====
// Top level of the round-robin poll sequencer.
// Instantiates rrps_cfg and rrps_core; depends on rrps_pkg.
//
// Each input item is one time tick: the current millisecond time and the
// device-ready, response-ready and read-ok flags. Every input item yields
// exactly one result item carrying the send and read strobes, the response
// and timeout events, the slot they refer to and the elapsed time.
// Both channels use valid and stall; an item moves at a clock edge where
// valid is high and stall is low.
// An accepted item is held in an input register, the step logic is
// combinational, and the result lands in an output register when the output
// side can advance; it can be taken at a clock edge where stall is low. One
// item is taken every cycle while the output side keeps up; the step through
// the sequencer state lies between the input and output registers.
// While the receiver stalls, the result is held, the input register fills and
// then in_stall rises until the result is taken.
// Reset returns the sequencer to its start phase at slot 0 with all run
// counts cleared and the registers at their reset values; the APB port is
// always ready and takes writes at any time.
module round_robin_poll_sequencer #(
  parameter int SLOTS       = 4,
  parameter int COUNT_WIDTH = 31,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [TIME_WIDTH-1:0]              now_ms,
  input  logic                               device_ready,
  input  logic                               response_ready,
  input  logic                               read_ok,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               send_request,
  output logic                               read_request,
  output logic                               response_event,
  output logic                               timeout_event,
  output logic [rrps_pkg::SLOT_IDX_W-1:0]    slot_index,
  output logic [rrps_pkg::ELAPSED_W-1:0]     elapsed_ms,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rrps_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [rrps_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [rrps_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import rrps_pkg::*;

  logic [SLOT_CNT_W-1:0]  slot_count;
  logic [LIMIT_W-1:0]     timeout_limit;
  logic [COUNT_WIDTH-1:0] max_runs [SLOTS];

  logic                  in_q_valid;
  logic [TIME_WIDTH-1:0] now_q;
  in_flags_t             flags_q;
  logic                  advance;
  logic                  fire;
  result_t               res;
  result_t               out_q;

  assign advance  = !out_valid || !out_stall;
  assign fire     = in_q_valid && advance;
  assign in_stall = in_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      now_q                  <= now_ms;
      flags_q.device_ready   <= device_ready;
      flags_q.response_ready <= response_ready;
      flags_q.read_ok        <= read_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign send_request   = out_q.send_request;
  assign read_request   = out_q.read_request;
  assign response_event = out_q.response_event;
  assign timeout_event  = out_q.timeout_event;
  assign slot_index     = out_q.slot_index;
  assign elapsed_ms     = out_q.elapsed_ms;

  rrps_cfg #(
    .SLOTS       (SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .slot_count    (slot_count),
    .timeout_limit (timeout_limit),
    .max_runs      (max_runs)
  );

  rrps_core #(
    .SLOTS       (SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .now_ms        (now_q),
    .flags         (flags_q),
    .slot_count    (slot_count),
    .timeout_limit (timeout_limit),
    .max_runs      (max_runs),
    .res           (res)
  );

endmodule

// ===== bench/poll_sequence_checker.sv =====
// Checker for the round-robin poll sequencer: follows register writes, predicts every
// result from the accepted items and compares each accepted result field by field.
// Depends on rrps_pkg for the register indexes, phase encoding and result layout.
module poll_sequence_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [31:0]                       now_ms,
  input  logic                              device_ready,
  input  logic                              response_ready,
  input  logic                              read_ok,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic                              send_request,
  input  logic                              read_request,
  input  logic                              response_event,
  input  logic                              timeout_event,
  input  logic [rrps_pkg::SLOT_IDX_W-1:0]   slot_index,
  input  logic [rrps_pkg::ELAPSED_W-1:0]    elapsed_ms,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [rrps_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [rrps_pkg::CFG_DATA_W-1:0]   pwdata,
  output int                                mismatch_count,
  output int                                strobes_due
);
  import rrps_pkg::*;

  localparam int SLOT_TOTAL = NUM_MAX_RUN_REGS;
  localparam logic [LIMIT_W-1:0] RUN_CEILING = '1;

  logic [SLOT_CNT_W-1:0] slot_cfg;
  logic [LIMIT_W-1:0]    timeout_cfg;
  logic [LIMIT_W-1:0]    run_limit [SLOT_TOTAL];
  logic [LIMIT_W-1:0]    run_tally [SLOT_TOTAL];
  phase_t                fsm_phase;
  int                    active_slot;
  logic [31:0]           sent_at;
  result_t               predicted_strobes [$];

  task report(string msg);
    if (mismatch_count < 200) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  task check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  function void move_to_next_slot();
    int in_use;
    in_use = (slot_cfg == 0) ? 1 : ((slot_cfg > SLOT_TOTAL) ? SLOT_TOTAL : int'(slot_cfg));
    if (active_slot + 1 >= in_use) begin
      active_slot = 0;
      fsm_phase = PH_START;
    end else begin
      active_slot++;
      fsm_phase = PH_SKIP;
    end
  endfunction

  function result_t advance_poll_fsm(logic [31:0] t, logic rdy, logic resp, logic ok);
    result_t r;
    logic [31:0] gap;
    r = '0;
    if (!rdy) begin
      fsm_phase = PH_START;
    end
    case (fsm_phase)
      PH_START: begin
        if (rdy) begin
          fsm_phase = PH_SKIP;
          active_slot = 0;
        end
      end
      PH_SKIP: begin
        if (active_slot >= SLOT_TOTAL) begin
          active_slot = 0;
          fsm_phase = PH_START;
        end else if (run_tally[active_slot] > run_limit[active_slot]) begin
          fsm_phase = PH_DONE;
        end else if (run_tally[active_slot] == RUN_CEILING) begin
          run_tally[active_slot] = '0;
        end else begin
          run_tally[active_slot] = run_tally[active_slot] + 1'b1;
          sent_at = t;
          fsm_phase = PH_WAIT;
          r.send_request = 1'b1;
          r.slot_index = active_slot[SLOT_IDX_W-1:0];
        end
      end
      PH_WAIT: begin
        gap = t - sent_at;
        if (gap > {1'b0, timeout_cfg}) begin
          fsm_phase = PH_TIMEOUT;
        end else if (resp) begin
          r.read_request = 1'b1;
          r.slot_index = active_slot[SLOT_IDX_W-1:0];
          if (ok) begin
            r.response_event = 1'b1;
            r.elapsed_ms = gap;
          end
          fsm_phase = PH_DONE;
        end
      end
      PH_TIMEOUT: begin
        r.timeout_event = 1'b1;
        r.slot_index = active_slot[SLOT_IDX_W-1:0];
        r.elapsed_ms = t - sent_at;
        move_to_next_slot();
      end
      PH_DONE: begin
        move_to_next_slot();
      end
      default: begin
        fsm_phase = PH_START;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t next_pred;
    logic [2:0] idx;
    if (rst) begin
      mismatch_count = 0;
      slot_cfg = 1;
      timeout_cfg = 100;
      for (int k = 0; k < SLOT_TOTAL; k++) begin
        run_limit[k] = RUN_CEILING;
        run_tally[k] = '0;
      end
      fsm_phase = PH_START;
      active_slot = 0;
      sent_at = '0;
      predicted_strobes.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        idx = paddr[4:2];
        if (idx == REG_SLOT_COUNT) begin
          slot_cfg = pwdata[SLOT_CNT_W-1:0];
        end else if (idx == REG_TIMEOUT) begin
          timeout_cfg = pwdata[LIMIT_W-1:0];
        end else if (idx >= REG_MAX_RUNS0 && idx < REG_MAX_RUNS0 + NUM_MAX_RUN_REGS) begin
          run_limit[idx - REG_MAX_RUNS0] = pwdata[LIMIT_W-1:0];
        end
      end
      if (in_valid && !in_stall) begin
        next_pred = advance_poll_fsm(now_ms, device_ready, response_ready, read_ok);
        predicted_strobes = {predicted_strobes, next_pred};
      end
      if (out_valid && !out_stall) begin
        if (predicted_strobes.size() == 0) begin
          report("result arrived with no item outstanding");
        end else begin
          want = predicted_strobes.pop_front();
          check_field("send_request", send_request, want.send_request);
          check_field("read_request", read_request, want.read_request);
          check_field("response_event", response_event, want.response_event);
          check_field("timeout_event", timeout_event, want.timeout_event);
          check_field("slot_index", slot_index, want.slot_index);
          check_field("elapsed_ms", elapsed_ms, want.elapsed_ms);
        end
      end
    end
    strobes_due = predicted_strobes.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the poll sequencer testbench: clock, reset, register programming, item
// stimulus with bursts and gaps, receiver stalls and the final verdict.
// Depends on rrps_pkg, round_robin_poll_sequencer and poll_sequence_checker.
module tb_top;
  import rrps_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 250;
  localparam logic [LIMIT_W-1:0] RUN_CEILING = '1;
  localparam logic [2:0] REG_PAST_END = 3'(REG_MAX_RUNS0 + NUM_MAX_RUN_REGS);

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [31:0]             now_ms;
  logic                    device_ready;
  logic                    response_ready;
  logic                    read_ok;
  logic                    out_valid;
  logic                    out_stall;
  logic                    send_request;
  logic                    read_request;
  logic                    response_event;
  logic                    timeout_event;
  logic [SLOT_IDX_W-1:0]   slot_index;
  logic [ELAPSED_W-1:0]    elapsed_ms;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CFG_ADDR_W-1:0]   paddr;
  logic [CFG_DATA_W-1:0]   pwdata;
  logic [CFG_DATA_W-1:0]   prdata;
  logic                    pready;
  int                      mismatch_count;
  int                      strobes_due;
  int                      cycle_count = 0;
  bit                      squeeze_req = 1'b0;
  bit                      squeeze_done = 1'b0;

  always #4 clk = ~clk;

  round_robin_poll_sequencer DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .now_ms(now_ms), .device_ready(device_ready),
    .response_ready(response_ready), .read_ok(read_ok),
    .out_valid(out_valid), .out_stall(out_stall),
    .send_request(send_request), .read_request(read_request),
    .response_event(response_event), .timeout_event(timeout_event),
    .slot_index(slot_index), .elapsed_ms(elapsed_ms),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  poll_sequence_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .now_ms(now_ms), .device_ready(device_ready),
    .response_ready(response_ready), .read_ok(read_ok),
    .out_valid(out_valid), .out_stall(out_stall),
    .send_request(send_request), .read_request(read_request),
    .response_event(response_event), .timeout_event(timeout_event),
    .slot_index(slot_index), .elapsed_ms(elapsed_ms),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatch_count(mismatch_count), .strobes_due(strobes_due)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stall patterns, plus one long hold-off while the sender keeps going.
  initial begin
    int mode;
    int span;
    int pct;
    out_stall = 1'b0;
    forever begin
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        repeat (300) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        mode = $urandom_range(0, 9);
        span = $urandom_range(10, 120);
        pct = $urandom_range(10, 80);
        for (int k = 0; k < span; k++) begin
          @(negedge clk);
          case (mode)
            0, 1, 2: out_stall <= 1'b0;
            3, 4, 5, 6: out_stall <= ($urandom_range(0, 99) < pct);
            7, 8: out_stall <= (k % 3 == 0);
            default: out_stall <= 1'b1;
          endcase
        end
      end
    end
  end

  task automatic send_tick(logic [31:0] t, logic rdy, logic resp, logic ok);
    @(negedge clk);
    in_valid <= 1'b1;
    now_ms <= t;
    device_ready <= rdy;
    response_ready <= resp;
    read_ok <= ok;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (strobes_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [LIMIT_W-1:0] pick_run_limit();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return RUN_CEILING;
      3: return LIMIT_W'($urandom_range(1, 3));
      default: return LIMIT_W'($urandom_range(10, 600));
    endcase
  endfunction

  initial begin
    int n;
    int burst;
    int step_max;
    logic [31:0] clock_ms;
    logic [SLOT_CNT_W-1:0] slots;
    logic [LIMIT_W-1:0] tmo;
    logic [LIMIT_W-1:0] lim;
    rst = 1'b1;
    in_valid = 1'b0;
    now_ms = '0;
    device_ready = 1'b0;
    response_ready = 1'b0;
    read_ok = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Default registers: one slot, 100 ms timeout, unlimited runs.
    send_tick(32'h0000_0000, 1'b0, 1'b0, 1'b0);
    send_tick(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b0);
    send_tick(32'hFFFF_FFF0, 1'b1, 1'b1, 1'b1);
    send_tick(32'hFFFF_FFF2, 1'b1, 1'b0, 1'b0);
    send_tick(32'h0000_0005, 1'b1, 1'b1, 1'b1);
    send_tick(32'd6, 1'b1, 1'b0, 1'b0);
    send_tick(32'd6, 1'b1, 1'b0, 1'b0);
    send_tick(32'd7, 1'b1, 1'b0, 1'b0);
    send_tick(32'd107, 1'b1, 1'b0, 1'b0);
    send_tick(32'd108, 1'b1, 1'b1, 1'b1);
    send_tick(32'd200, 1'b1, 1'b0, 1'b0);
    send_tick(32'd200, 1'b1, 1'b0, 1'b0);
    send_tick(32'd201, 1'b1, 1'b0, 1'b0);
    send_tick(32'd201, 1'b1, 1'b1, 1'b0);
    send_tick(32'd202, 1'b1, 1'b0, 1'b0);
    send_tick(32'd203, 1'b1, 1'b0, 1'b0);
    send_tick(32'd204, 1'b1, 1'b0, 1'b0);
    send_tick(32'd205, 1'b0, 1'b1, 1'b1);
    send_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    send_tick(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
    send_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    send_tick(32'h0000_0000, 1'b1, 1'b0, 1'b0);
    settle();

    clock_ms = $urandom;
    for (int p = 1; p <= PHASES; p++) begin
      case (p)
        1: slots = 4;
        2: slots = 7;
        3: slots = 0;
        4: slots = 1;
        5: slots = 3;
        default: slots = SLOT_CNT_W'($urandom_range(0, 7));
      endcase
      case (p)
        1: tmo = '0;
        2: tmo = RUN_CEILING;
        3: tmo = 100;
        default: tmo = LIMIT_W'($urandom_range(0, 60));
      endcase
      write_reg(REG_SLOT_COUNT, ($urandom & 32'hFFFF_FFF8) | slots);
      write_reg(REG_TIMEOUT, ($urandom & 32'h8000_0000) | tmo);
      for (int k = 0; k < NUM_MAX_RUN_REGS; k++) begin
        if (p == 2 && k == 0) begin
          lim = '0;
        end else if (p == 3) begin
          lim = RUN_CEILING;
        end else begin
          lim = pick_run_limit();
        end
        write_reg(3'(REG_MAX_RUNS0 + k), ($urandom & 32'h8000_0000) | lim);
      end
      if (p == 4) begin
        write_reg(REG_PAST_END, $urandom);
        write_reg(REG_PAST_END + 3'd1, $urandom);
      end
      case ($urandom_range(0, 2))
        0: step_max = 1;
        1: step_max = 4;
        default: step_max = 40;
      endcase
      if (p == 1) begin
        squeeze_req = 1'b1;
      end
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        burst = $urandom_range(1, 40);
        repeat (burst) begin
          if ($urandom_range(0, 29) == 0) begin
            clock_ms = $urandom;
          end else begin
            clock_ms = clock_ms + $urandom_range(0, step_max);
          end
          send_tick(clock_ms, $urandom_range(0, 39) != 0, $urandom_range(0, 3) == 0,
                    $urandom_range(0, 3) != 0);
          n++;
        end
        if ($urandom_range(0, 3) != 0) begin
          pause_sender($urandom_range(1, 8));
        end
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rrps_pkg.sv
src/rrps_cfg.sv
src/rrps_core.sv
src/round_robin_poll_sequencer.sv
bench/poll_sequence_checker.sv
bench/tb_top.sv
